### design/ast_pkg.sv
// shared types and constants for the assembly source tokenizer
package ast_pkg;

  // number of result slots one source byte can produce
  localparam int MaxRes = 3;
  // depth of the queue between front and back
  localparam int QDepth = 4;

  // one result word without its position
  typedef struct packed {
    logic       kind;
    logic [4:0] ttype;
    logic [7:0] tbyte;
  } res_t;

  // all results caused by one accepted source byte
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [1:0]        cnt;
  } bundle_t;

endpackage

### design/assembly_source_tokenizer.sv
// tokenizer for assembler source text, one source byte per input word
// latency: the results of a byte pass through the bundle queue and then the output register before they show on out_
// throughput: one byte per cycle while in_stall is low; results leave at one word per cycle
//   while out_stall is low, so a byte with two or three results holds the output longer,
//   with a four-bundle queue between scanner and output register absorbing bursts
// reset: synchronous, rst_n low; scanner idle, line and column one, queue empty
module assembly_source_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_ch,
  input  logic                     in_is_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [4:0]               out_token_type,
  output logic [7:0]               out_text_byte,
  output logic [POSITION_BITS-1:0] out_start_line,
  output logic [POSITION_BITS-1:0] out_start_column,
  output logic                     out_last_of_run
);

  logic                                          acc, push, pop, q_valid, q_full;
  ast_pkg::bundle_t                              fe_bun, q_bun;
  logic [ast_pkg::MaxRes-1:0][POSITION_BITS-1:0] fe_line, fe_col, q_line, q_col;

  // input handshake
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // scanner
  ast_front #(.PB(POSITION_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .ch     (in_ch),
    .is_end (in_is_end),
    .push   (push),
    .bun    (fe_bun),
    .bline  (fe_line),
    .bcol   (fe_col)
  );

  // bundle queue
  ast_queue #(.PB(POSITION_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_bun    (fe_bun),
    .wr_line   (fe_line),
    .wr_col    (fe_col),
    .pop       (pop),
    .not_empty (q_valid),
    .full      (q_full),
    .rd_bun    (q_bun),
    .rd_line   (q_line),
    .rd_col    (q_col)
  );

  // result output
  ast_back #(.PB(POSITION_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_bun            (q_bun),
    .q_line           (q_line),
    .q_col            (q_col),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_token_type   (out_token_type),
    .out_text_byte    (out_text_byte),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### design/ast_front.sv
// front end: accepts source bytes, scans them and builds result bundles
module ast_front #(
  parameter int PB = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 acc,
  input  logic [7:0]                           ch,
  input  logic                                 is_end,
  output logic                                 push,
  output ast_pkg::bundle_t                     bun,
  output logic [ast_pkg::MaxRes-1:0][PB-1:0]   bline,
  output logic [ast_pkg::MaxRes-1:0][PB-1:0]   bcol
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_HEX, M_BIN, M_DEC, M_STR, M_ESC
  } mode_t;

  // token type codes
  localparam logic [4:0] T_EOF = 5'd0;
  localparam logic [4:0] T_NL = 5'd1;
  localparam logic [4:0] T_IDENT = 5'd2;
  localparam logic [4:0] T_NUM = 5'd3;
  localparam logic [4:0] T_STR = 5'd4;
  localparam logic [4:0] T_ORG = 5'd5;
  localparam logic [4:0] T_WORD = 5'd6;
  localparam logic [4:0] T_BYTE = 5'd7;
  localparam logic [4:0] T_X = 5'd8;
  localparam logic [4:0] T_Y = 5'd9;
  localparam logic [4:0] T_PLUS = 5'd10;
  localparam logic [4:0] T_MINUS = 5'd11;
  localparam logic [4:0] T_HASH = 5'd12;
  localparam logic [4:0] T_COMMA = 5'd13;
  localparam logic [4:0] T_COLON = 5'd14;
  localparam logic [4:0] T_LP = 5'd15;
  localparam logic [4:0] T_RP = 5'd16;
  localparam logic [4:0] T_LB = 5'd17;
  localparam logic [4:0] T_RB = 5'd18;
  localparam logic [4:0] T_UNK = 5'd19;

  // characters
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_VT = 8'h0B;
  localparam logic [7:0] C_FF = 8'h0C;
  localparam logic [7:0] C_CR = 8'h0D;
  localparam logic [7:0] C_SP = 8'h20;
  localparam logic [7:0] C_QUOTE = 8'h22;
  localparam logic [7:0] C_DOLLAR = 8'h24;
  localparam logic [7:0] C_PCT = 8'h25;
  localparam logic [7:0] C_SEMI = 8'h3B;
  localparam logic [7:0] C_BSL = 8'h5C;
  localparam logic [7:0] C_DOT = 8'h2E;
  localparam logic [7:0] C_USC = 8'h5F;

  localparam logic [PB-1:0] PosMax = {PB{1'b1}};
  localparam logic [PB-1:0] PosOne = {{(PB-1){1'b0}}, 1'b1};

  mode_t           mode_r, mode_nxt;
  logic [4:0][7:0] pfx_r, pfx_nxt;
  logic [2:0]      wlen_r, wlen_nxt;
  logic [PB-1:0]   tl_r, tl_nxt, tc_r, tc_nxt, cl_r, cl_nxt, cc_r, cc_nxt;

  logic [1:0]  n;
  logic        fresh;
  logic        pending;
  logic [4:0]  pend_type;
  logic [4:0]  id_type;
  logic [7:0]  esc_val;
  logic        c_letter, c_dec, c_hex, c_word, c_blank;

  function automatic ast_pkg::res_t mk(input logic k, input logic [4:0] t, input logic [7:0] b);
    ast_pkg::res_t r;
    r.kind = k;
    r.ttype = t;
    r.tbyte = b;
    return r;
  endfunction

  function automatic logic [4:0] punct(input logic [7:0] c);
    logic [4:0] t;
    case (c)
      8'h2B:   t = T_PLUS;
      8'h2D:   t = T_MINUS;
      8'h23:   t = T_HASH;
      8'h2C:   t = T_COMMA;
      8'h3A:   t = T_COLON;
      8'h28:   t = T_LP;
      8'h29:   t = T_RP;
      8'h5B:   t = T_LB;
      8'h5D:   t = T_RB;
      default: t = T_UNK;
    endcase
    return t;
  endfunction

  // character classes
  always_comb begin
    c_letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    c_dec    = ch >= 8'h30 && ch <= 8'h39;
    c_hex    = c_dec || (ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66);
    c_word   = c_letter || c_dec || ch == C_USC;
    c_blank  = ch == C_SP || ch == C_TAB || ch == C_VT || ch == C_FF || ch == C_CR;
    case (ch)
      8'h6E:   esc_val = C_LF;
      8'h74:   esc_val = C_TAB;
      8'h72:   esc_val = C_CR;
      default: esc_val = ch;
    endcase
  end

  // keyword match on the stored identifier prefix
  always_comb begin
    id_type = T_IDENT;
    if (wlen_r == 3'd1 && pfx_r[0] == 8'h58) begin
      id_type = T_X;
    end else if (wlen_r == 3'd1 && pfx_r[0] == 8'h59) begin
      id_type = T_Y;
    end else if ((wlen_r == 3'd4 && pfx_r[0] == C_DOT && pfx_r[1] == 8'h6F &&
                  pfx_r[2] == 8'h72 && pfx_r[3] == 8'h67) ||
                 (wlen_r == 3'd3 && pfx_r[0] == 8'h6F && pfx_r[1] == 8'h72 &&
                  pfx_r[2] == 8'h67)) begin
      id_type = T_ORG;
    end else if ((wlen_r == 3'd5 && pfx_r[0] == C_DOT && pfx_r[1] == 8'h77 &&
                  pfx_r[2] == 8'h6F && pfx_r[3] == 8'h72 && pfx_r[4] == 8'h64) ||
                 (wlen_r == 3'd4 && pfx_r[0] == 8'h77 && pfx_r[1] == 8'h6F &&
                  pfx_r[2] == 8'h72 && pfx_r[3] == 8'h64)) begin
      id_type = T_WORD;
    end else if ((wlen_r == 3'd5 && pfx_r[0] == C_DOT && pfx_r[1] == 8'h62 &&
                  pfx_r[2] == 8'h79 && pfx_r[3] == 8'h74 && pfx_r[4] == 8'h65) ||
                 (wlen_r == 3'd4 && pfx_r[0] == 8'h62 && pfx_r[1] == 8'h79 &&
                  pfx_r[2] == 8'h74 && pfx_r[3] == 8'h65)) begin
      id_type = T_BYTE;
    end
  end

  // type of the token left open in the current mode
  always_comb begin
    pending = 1'b1;
    case (mode_r)
      M_IDENT:                pend_type = id_type;
      M_HEX, M_BIN, M_DEC:    pend_type = T_NUM;
      M_STR, M_ESC:           pend_type = T_STR;
      default: begin
        pend_type = T_EOF;
        pending = 1'b0;
      end
    endcase
  end

  // scanner next state and result bundle
  always_comb begin
    mode_nxt = mode_r;
    pfx_nxt  = pfx_r;
    wlen_nxt = wlen_r;
    tl_nxt   = tl_r;
    tc_nxt   = tc_r;
    cl_nxt   = cl_r;
    cc_nxt   = cc_r;
    n        = 2'd0;
    fresh    = 1'b0;
    bun      = '0;
    bline    = '0;
    bcol     = '0;

    if (is_end || ch == 8'h00) begin
      // end of source: close pending token, emit end of file, back to reset
      if (pending) begin
        bun.res[n] = mk(1'b1, pend_type, 8'h00);
        bline[n] = tl_r;
        bcol[n] = tc_r;
        n = n + 2'd1;
      end
      bun.res[n] = mk(1'b1, T_EOF, 8'h00);
      bline[n] = cl_r;
      bcol[n] = cc_r;
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      pfx_nxt  = '0;
      wlen_nxt = '0;
      tl_nxt   = PosOne;
      tc_nxt   = PosOne;
      cl_nxt   = PosOne;
      cc_nxt   = PosOne;
    end else begin
      // position advance
      if (ch == C_LF) begin
        if (cl_r != PosMax) cl_nxt = cl_r + PosOne;
        cc_nxt = PosOne;
      end else if (cc_r != PosMax) begin
        cc_nxt = cc_r + PosOne;
      end

      // continue the pending token where the byte fits
      case (mode_r)
        M_COMMENT: begin
          if (ch == C_LF) fresh = 1'b1;
        end
        M_IDENT: begin
          if (c_word) begin
            if (wlen_r < 3'd5) pfx_nxt[wlen_r] = ch;
            if (wlen_r < 3'd6) wlen_nxt = wlen_r + 3'd1;
            bun.res[n] = mk(1'b0, T_EOF, ch);
            bline[n] = tl_r;
            bcol[n] = tc_r;
            n = n + 2'd1;
          end else begin
            bun.res[n] = mk(1'b1, pend_type, 8'h00);
            bline[n] = tl_r;
            bcol[n] = tc_r;
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_HEX, M_BIN, M_DEC: begin
          if ((mode_r == M_HEX && c_hex) || (mode_r == M_DEC && c_dec) ||
              (mode_r == M_BIN && (ch == 8'h30 || ch == 8'h31))) begin
            bun.res[n] = mk(1'b0, T_EOF, ch);
            bline[n] = tl_r;
            bcol[n] = tc_r;
            n = n + 2'd1;
          end else begin
            bun.res[n] = mk(1'b1, T_NUM, 8'h00);
            bline[n] = tl_r;
            bcol[n] = tc_r;
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        M_STR: begin
          if (ch == C_QUOTE) begin
            bun.res[n] = mk(1'b1, T_STR, 8'h00);
            mode_nxt = M_IDLE;
          end else if (ch == C_BSL) begin
            mode_nxt = M_ESC;
          end else begin
            bun.res[n] = mk(1'b0, T_EOF, ch);
          end
          bline[n] = tl_r;
          bcol[n] = tc_r;
          if (ch != C_BSL) n = n + 2'd1;
        end
        M_ESC: begin
          bun.res[n] = mk(1'b0, T_EOF, esc_val);
          bline[n] = tl_r;
          bcol[n] = tc_r;
          n = n + 2'd1;
          mode_nxt = M_STR;
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // start of a new token at the current position
      if (fresh) begin
        mode_nxt = M_IDLE;
        tl_nxt = cl_r;
        tc_nxt = cc_r;
        bline[n] = cl_r;
        bcol[n] = cc_r;
        if (c_blank) begin
          mode_nxt = M_IDLE;
        end else if (ch == C_LF) begin
          bun.res[n] = mk(1'b1, T_NL, 8'h00);
          n = n + 2'd1;
        end else if (ch == C_SEMI) begin
          mode_nxt = M_COMMENT;
        end else if (c_letter || ch == C_USC || ch == C_DOT) begin
          mode_nxt = M_IDENT;
          pfx_nxt = '0;
          pfx_nxt[0] = ch;
          wlen_nxt = 3'd1;
          bun.res[n] = mk(1'b0, T_EOF, ch);
          n = n + 2'd1;
        end else if (c_dec || ch == C_DOLLAR || ch == C_PCT) begin
          mode_nxt = (ch == C_DOLLAR) ? M_HEX : (ch == C_PCT) ? M_BIN : M_DEC;
          bun.res[n] = mk(1'b0, T_EOF, ch);
          n = n + 2'd1;
        end else if (ch == C_QUOTE) begin
          mode_nxt = M_STR;
        end else begin
          bun.res[n] = mk(1'b0, T_EOF, ch);
          n = n + 2'd1;
          bline[n] = cl_r;
          bcol[n] = cc_r;
          bun.res[n] = mk(1'b1, punct(ch), 8'h00);
          n = n + 2'd1;
        end
      end
    end
    bun.cnt = n;
    push = acc && (n != 2'd0);
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pfx_r  <= '0;
      wlen_r <= '0;
      tl_r   <= PosOne;
      tc_r   <= PosOne;
      cl_r   <= PosOne;
      cc_r   <= PosOne;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pfx_r  <= pfx_nxt;
      wlen_r <= wlen_nxt;
      tl_r   <= tl_nxt;
      tc_r   <= tc_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
    end
  end

endmodule

### design/ast_queue.sv
// short queue of result bundles between front and back
module ast_queue #(
  parameter int PB = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  ast_pkg::bundle_t                     wr_bun,
  input  logic [ast_pkg::MaxRes-1:0][PB-1:0]   wr_line,
  input  logic [ast_pkg::MaxRes-1:0][PB-1:0]   wr_col,
  input  logic                                 pop,
  output logic                                 not_empty,
  output logic                                 full,
  output ast_pkg::bundle_t                     rd_bun,
  output logic [ast_pkg::MaxRes-1:0][PB-1:0]   rd_line,
  output logic [ast_pkg::MaxRes-1:0][PB-1:0]   rd_col
);

  localparam int AW = $clog2(ast_pkg::QDepth);

  ast_pkg::bundle_t                    bun_q [ast_pkg::QDepth];
  logic [ast_pkg::MaxRes-1:0][PB-1:0]  line_q [ast_pkg::QDepth];
  logic [ast_pkg::MaxRes-1:0][PB-1:0]  col_q [ast_pkg::QDepth];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == (AW+1)'(ast_pkg::QDepth);
  assign rd_bun    = bun_q[rd_ptr_r];
  assign rd_line   = line_q[rd_ptr_r];
  assign rd_col    = col_q[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      bun_q[wr_ptr_r]  <= wr_bun;
      line_q[wr_ptr_r] <= wr_line;
      col_q[wr_ptr_r]  <= wr_col;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + AW'(1);
      if (push && !pop) cnt_r <= cnt_r + (AW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end

endmodule

### design/ast_back.sv
// back end: sends the results of each bundle one word per cycle while out_stall is low
module ast_back #(
  parameter int PB = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  ast_pkg::bundle_t                     q_bun,
  input  logic [ast_pkg::MaxRes-1:0][PB-1:0]   q_line,
  input  logic [ast_pkg::MaxRes-1:0][PB-1:0]   q_col,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_result_kind,
  output logic [4:0]                           out_token_type,
  output logic [7:0]                           out_text_byte,
  output logic [PB-1:0]                        out_start_line,
  output logic [PB-1:0]                        out_start_column,
  output logic                                 out_last_of_run
);

  logic          valid_r;
  logic [1:0]    sub_r;
  ast_pkg::res_t res_r;
  logic [PB-1:0] line_r, col_r;
  logic          last_r;
  logic          load, last_sub;

  assign load     = q_valid && (!valid_r || !out_stall);
  assign last_sub = sub_r == (q_bun.cnt - 2'd1);
  assign q_pop    = load && last_sub;

  assign out_valid        = valid_r;
  assign out_result_kind  = res_r.kind;
  assign out_token_type   = res_r.ttype;
  assign out_text_byte    = res_r.tbyte;
  assign out_start_line   = line_r;
  assign out_start_column = col_r;
  assign out_last_of_run  = last_r;

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= q_bun.res[sub_r];
      line_r <= q_line[sub_r];
      col_r  <= q_col[sub_r];
      last_r <= last_sub;
    end
  end

  // slot walk and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= last_sub ? 2'd0 : sub_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

### sim/assembly_source_tokenizer_test.sv
// testbench for the assembly source tokenizer: source bytes in, token words checked in order
`timescale 1ns / 1ps

module assembly_source_tokenizer_test;

  localparam int PosBits = 16;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam int RandomBytes = 440;

  // source characters with a meaning of their own
  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChNewline    = 8'h0a;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChDollar     = 8'h24;
  localparam logic [7:0] ChPercent    = 8'h25;
  localparam logic [7:0] ChDot        = 8'h2e;
  localparam logic [7:0] ChSemicolon  = 8'h3b;
  localparam logic [7:0] ChBackslash  = 8'h5c;
  localparam logic [7:0] ChUnderscore = 8'h5f;

  typedef enum logic [2:0] {
    ScanIdle, ScanComment, ScanWord, ScanHex, ScanBin, ScanDec, ScanString, ScanEscape
  } scan_mode_e;

  typedef enum logic [4:0] {
    TokEof, TokNewline, TokIdent, TokNumber, TokString, TokOrg, TokWord, TokByte,
    TokRegX, TokRegY, TokPlus, TokMinus, TokHash, TokComma, TokColon, TokLParen,
    TokRParen, TokLBracket, TokRBracket, TokUnknown
  } token_e;

  localparam logic KindText  = 1'b0;
  localparam logic KindClose = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [4:0]         ttype;
    logic [7:0]         tbyte;
    logic [PosBits-1:0] ln;
    logic [PosBits-1:0] col;
    logic               last;
  } token_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    logic       hold;
  } source_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic in_is_end = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_result_kind;
  logic [4:0] out_token_type;
  logic [7:0] out_text_byte;
  logic [PosBits-1:0] out_start_line;
  logic [PosBits-1:0] out_start_column;
  logic out_last_of_run;

  assembly_source_tokenizer #(
    .POSITION_BITS(PosBits)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_is_end        (in_is_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_token_type   (out_token_type),
    .out_text_byte    (out_text_byte),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  source_item_t source_bytes [$];
  token_word_t  due_words [$];
  int fail_count = 0;

  // scanner shadow state
  scan_mode_e         scan_mode;
  logic [7:0]         word_chars [0:4];
  int                 word_len;
  logic [PosBits-1:0] tok_line, tok_col, cur_line, cur_col;
  token_word_t        step_words [0:3];
  int                 step_count;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return is_dec_char(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || is_dec_char(c) || c == ChUnderscore;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic logic [4:0] punct_type(input logic [7:0] c);
    case (c)
      "+": return TokPlus;
      "-": return TokMinus;
      "#": return TokHash;
      ",": return TokComma;
      ":": return TokColon;
      "(": return TokLParen;
      ")": return TokRParen;
      "[": return TokLBracket;
      "]": return TokRBracket;
      default: return TokUnknown;
    endcase
  endfunction

  task automatic reset_scanner();
    int i;
    scan_mode = ScanIdle;
    for (i = 0; i < 5; i++) word_chars[i] = 8'h00;
    word_len = 0;
    tok_line = PosBits'(1);
    tok_col = PosBits'(1);
    cur_line = PosBits'(1);
    cur_col = PosBits'(1);
  endtask

  task automatic stage_word(input logic kind, input logic [4:0] t, input logic [7:0] b,
                            input logic [PosBits-1:0] ln, input logic [PosBits-1:0] col);
    token_word_t w;
    w.kind = kind;
    w.ttype = t;
    w.tbyte = b;
    w.ln = ln;
    w.col = col;
    w.last = 1'b0;
    step_words[step_count] = w;
    step_count++;
  endtask

  task automatic advance_position(input logic [7:0] c);
    if (c == ChNewline) begin
      if (cur_line != PosMax) cur_line++;
      cur_col = PosBits'(1);
    end else if (cur_col != PosMax) begin
      cur_col++;
    end
  endtask

  function automatic logic word_matches(input string k);
    int i;
    if (word_len != k.len()) return 1'b0;
    for (i = 0; i < k.len(); i++) begin
      if (word_chars[i] != k[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [4:0] keyword_type();
    if (word_matches("X")) return TokRegX;
    if (word_matches("Y")) return TokRegY;
    if (word_matches(".org") || word_matches("org")) return TokOrg;
    if (word_matches(".word") || word_matches("word")) return TokWord;
    if (word_matches(".byte") || word_matches("byte")) return TokByte;
    return TokIdent;
  endfunction

  task automatic add_prefix(input logic [7:0] c);
    if (word_len < 5) word_chars[word_len] = c;
    if (word_len < 6) word_len++;
  endtask

  task automatic close_open_token();
    case (scan_mode)
      ScanWord: stage_word(KindClose, keyword_type(), 8'h00, tok_line, tok_col);
      ScanHex, ScanBin, ScanDec: stage_word(KindClose, TokNumber, 8'h00, tok_line, tok_col);
      ScanString, ScanEscape: stage_word(KindClose, TokString, 8'h00, tok_line, tok_col);
      default: ;
    endcase
    scan_mode = ScanIdle;
  endtask

  // expected token words for one accepted source byte
  task automatic tokenize_byte(input logic [7:0] c, input logic is_end);
    logic finished;
    logic more;
    logic [7:0] v;
    int i;
    token_word_t w;
    step_count = 0;
    finished = 1'b0;
    if (is_end || c == ChNul) begin
      close_open_token();
      stage_word(KindClose, TokEof, 8'h00, cur_line, cur_col);
      reset_scanner();
    end else begin
      case (scan_mode)
        ScanComment: begin
          if (c != ChNewline) begin
            advance_position(c);
            finished = 1'b1;
          end else begin
            scan_mode = ScanIdle;
          end
        end
        ScanWord: begin
          if (is_word_char(c)) begin
            add_prefix(c);
            stage_word(KindText, TokEof, c, tok_line, tok_col);
            advance_position(c);
            finished = 1'b1;
          end else begin
            close_open_token();
          end
        end
        ScanHex, ScanBin, ScanDec: begin
          if (scan_mode == ScanHex) more = is_hex_char(c);
          else if (scan_mode == ScanBin) more = (c == "0" || c == "1");
          else more = is_dec_char(c);
          if (more) begin
            stage_word(KindText, TokEof, c, tok_line, tok_col);
            advance_position(c);
            finished = 1'b1;
          end else begin
            close_open_token();
          end
        end
        ScanString: begin
          if (c == ChQuote) close_open_token();
          else if (c == ChBackslash) scan_mode = ScanEscape;
          else stage_word(KindText, TokEof, c, tok_line, tok_col);
          advance_position(c);
          finished = 1'b1;
        end
        ScanEscape: begin
          if (c == "n") v = 8'h0a;
          else if (c == "t") v = 8'h09;
          else if (c == "r") v = 8'h0d;
          else v = c;
          stage_word(KindText, TokEof, v, tok_line, tok_col);
          scan_mode = ScanString;
          advance_position(c);
          finished = 1'b1;
        end
        default: scan_mode = ScanIdle;
      endcase
      // start of the next token
      if (!finished) begin
        tok_line = cur_line;
        tok_col = cur_col;
        if (is_blank(c)) begin
        end else if (c == ChNewline) begin
          stage_word(KindClose, TokNewline, 8'h00, tok_line, tok_col);
        end else if (c == ChSemicolon) begin
          scan_mode = ScanComment;
        end else if (is_letter(c) || c == ChUnderscore || c == ChDot) begin
          scan_mode = ScanWord;
          for (i = 0; i < 5; i++) word_chars[i] = 8'h00;
          word_len = 0;
          add_prefix(c);
          stage_word(KindText, TokEof, c, tok_line, tok_col);
        end else if (is_dec_char(c) || c == ChDollar || c == ChPercent) begin
          if (c == ChDollar) scan_mode = ScanHex;
          else if (c == ChPercent) scan_mode = ScanBin;
          else scan_mode = ScanDec;
          stage_word(KindText, TokEof, c, tok_line, tok_col);
        end else if (c == ChQuote) begin
          scan_mode = ScanString;
        end else begin
          stage_word(KindText, TokEof, c, tok_line, tok_col);
          stage_word(KindClose, punct_type(c), 8'h00, tok_line, tok_col);
        end
        advance_position(c);
      end
    end
    for (i = 0; i < step_count; i++) begin
      w = step_words[i];
      w.last = (i == step_count - 1);
      due_words.insert(due_words.size(), w);
    end
  endtask

  // stimulus building
  task automatic send_item(input logic [7:0] c, input logic is_end, input logic hold);
    source_item_t s;
    s.ch = c;
    s.is_end = is_end;
    s.hold = hold;
    source_bytes.insert(source_bytes.size(), s);
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(c, 1'b0, 1'b0);
  endtask

  task automatic send_end(input logic [7:0] c);
    send_item(c, 1'b1, 1'b0);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] random_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return ChUnderscore;
  endfunction

  function automatic logic [7:0] random_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic string keyword_like(input int k);
    case (k)
      0: return "org";
      1: return ".org";
      2: return "word";
      3: return ".word";
      4: return "byte";
      5: return ".byte";
      6: return "X";
      7: return "Y";
      8: return "x";
      9: return "lda";
      10: return "sta";
      11: return "wordy";
      12: return ".bytes";
      13: return "orgX";
      14: return "XY";
      15: return ".";
      16: return "_loop1";
      default: return "Byte";
    endcase
  endfunction

  task automatic add_name();
    int n, i, r;
    if ($urandom_range(0, 2) != 0) begin
      send_text(keyword_like($urandom_range(0, 17)));
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0) send_byte(ChDot);
      else if (r == 1) send_byte(ChUnderscore);
      else send_byte(8'("a" + $urandom_range(0, 25) - (r > 5 ? 32 : 0)));
      n = $urandom_range(0, 7);
      for (i = 0; i < n; i++) send_byte(random_word_char());
    end
  endtask

  task automatic add_string();
    int n, i, r;
    logic [7:0] pick;
    send_byte(ChQuote);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        send_byte(ChBackslash);
        case ($urandom_range(0, 6))
          0: pick = "n";
          1: pick = "t";
          2: pick = "r";
          3: pick = ChBackslash;
          4: pick = ChQuote;
          5: pick = "q";
          default: pick = 8'($urandom_range(1, 255));
        endcase
        send_byte(pick);
      end else if (r == 2) begin
        send_byte(ChNewline);
      end else begin
        send_byte(8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 7) != 0) send_byte(ChQuote);
  endtask

  task automatic add_element();
    int n, i;
    string punct;
    punct = "+-#,:()[]";
    case ($urandom_range(0, 9))
      0, 1, 2: add_name();
      3: begin
        send_byte(ChDollar);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) send_byte(random_hex_digit());
      end
      4: begin
        send_byte(ChPercent);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 1)));
      end
      5: begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
      end
      6: add_string();
      7, 8: send_byte(punct[$urandom_range(0, 8)]);
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic add_blanks();
    int n, i;
    n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: send_byte(8'h09);
        1: send_byte(8'h0b);
        2: send_byte(8'h0c);
        3: send_byte(8'h0d);
        default: send_byte(8'h20);
      endcase
    end
  endtask

  // one line of assembler text, or now and then noise or a broken fragment
  task automatic add_source_line();
    int sel, n, i;
    logic [7:0] c;
    logic ended;
    ended = 1'b0;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end else if (sel == 1) begin
      // dangling escape cut off by the end of source
      send_byte(ChQuote);
      send_byte(8'($urandom_range(32, 126)));
      send_byte(ChBackslash);
      send_end(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        add_blanks();
        add_element();
      end
      if ($urandom_range(0, 2) == 0) begin
        send_byte(ChSemicolon);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
          c = 8'($urandom_range(1, 255));
          send_byte(c == ChNewline ? 8'h63 : c);
        end
        if ($urandom_range(0, 4) == 0) begin
          send_end(8'($urandom_range(0, 255)));
          ended = 1'b1;
        end
      end
      if (!ended) send_byte(ChNewline);
    end
    case ($urandom_range(0, 11))
      0: send_end(8'($urandom_range(0, 255)));
      1: send_byte(ChNul);
      default: ;
    endcase
  endtask

  // sender: bursts of words with random gaps, hold markers wait for a full drain
  int burst_left = 0;
  int gap_left = 0;
  source_item_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch <= 8'h00;
      in_is_end <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tokenize_byte(in_ch, in_is_end);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (source_bytes.size() > 0) begin
          head = source_bytes[0];
          if (head.hold) begin
            in_valid <= 1'b0;
            if (due_words.size() == 0) void'(source_bytes.pop_front());
          end else begin
            void'(source_bytes.pop_front());
            in_ch <= head.ch;
            in_is_end <= head.is_end;
            in_valid <= 1'b1;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 40);
              gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end else begin
              burst_left--;
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic logic [15:0] pick_stall_pattern();
    case ($urandom_range(0, 5))
      0, 1: return 16'h0000;
      2: return 16'h8421;
      3: return 16'hcccc;
      4: return 16'hf0f0;
      default: return 16'h7777;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (want !== seen) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
    end
  endtask

  // receiver: stall pattern picked anew every window, each taken word checked in order
  logic [15:0] stall_bits = 16'h0000;
  int window_left = 0;
  token_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got kind %0h type %0h byte %0h",
                   $time, out_result_kind, out_token_type, out_text_byte);
        end else begin
          want = due_words.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(out_result_kind));
          check_field("token_type", 16'(want.ttype), 16'(out_token_type));
          check_field("text_byte", 16'(want.tbyte), 16'(out_text_byte));
          check_field("start_line", want.ln, out_start_line);
          check_field("start_column", want.col, out_start_column);
          check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
        end
      end
      if (window_left == 0) begin
        stall_bits = pick_stall_pattern();
        window_left = $urandom_range(40, 160);
      end else begin
        window_left--;
      end
      out_stall <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
    end
  end

  initial begin
    int i;
    int random_start;
    logic held;
    reset_scanner();

    // directed: keyword, registers, comma, comment, newline token
    send_text(".word X,Y;c");
    send_byte(ChNewline);
    // string with escapes and a raw newline, closed by an end word
    send_byte(ChQuote);
    send_byte(ChBackslash);
    send_byte("t");
    send_byte(ChBackslash);
    send_byte(ChQuote);
    send_byte(ChNewline);
    send_end(8'hff);
    // non-ascii bytes, binary then hex number, zero byte as end of source
    send_byte(8'hff);
    send_byte(8'h80);
    send_text("%1$9");
    send_byte(ChNul);
    send_item(8'h00, 1'b0, 1'b1);

    // keyword directly followed by punctuation
    send_text("  byte+");
    send_byte(ChNewline);
    // register, then a closed string, then the end of source
    send_text("Y \"s\"");
    send_end(8'h00);

    // random source text
    random_start = source_bytes.size();
    held = 1'b0;
    while (source_bytes.size() < random_start + RandomBytes) begin
      add_source_line();
      if (!held && source_bytes.size() > random_start + RandomBytes / 2) begin
        send_item(8'h00, 1'b0, 1'b1);
        held = 1'b1;
      end
    end
    send_end(8'h00);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (source_bytes.size() > 0 || in_valid) @(posedge clk);
    while (due_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
design/ast_pkg.sv
design/ast_front.sv
design/ast_queue.sv
design/ast_back.sv
design/assembly_source_tokenizer.sv
sim/assembly_source_tokenizer_test.sv
